FILE: design/bfec_pkg.sv
// shared types, codes and constants of the brainfuck execution core
package bfec_pkg;

  localparam int PROG_DEPTH_DEF = 4096;
  localparam int TAPE_DEPTH_DEF = 1024;

  localparam int ACTION_W    = 2;
  localparam int ADDR_W      = 12;
  localparam int BYTE_W      = 8;
  localparam int PLEN_W      = 13;
  localparam int TSTART_W    = 10;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // quotient of a load address by the smallest store depth fits in this many bits
  localparam int ADDR_RED_STEPS = 8;

  localparam logic [PLEN_W-1:0]   PROG_LEN_RST   = '0;
  localparam int                  TAPE_START_RST = 341;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_START     = 1'd1;

  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_STEP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  localparam logic [STAT_W-1:0] STAT_RUN         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DONE        = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TAPE_ERR    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BRACKET_ERR = 2'd3;

  localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] run_status;
    logic              took_input;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
  } res_t;

endpackage

FILE: design/brainfuck_execution_core_top.sv
// top level: stream ports, configuration, core and output register
// load and idle-action beats pass through RESULT and the output register to out_tvalid; steps add EXEC
// bracket scans add a SCAN_RD and a SCAN_CHK state per program byte walked through the program store port
// restart beats clear the tape one cell per cycle, from the first cell to the last
// a new beat is taken only in IDLE, after the previous result is handed on, as set by the single-port memories
// after reset the tape is cleared with in_tready low; cfg is always ready
module brainfuck_execution_core_top #(
  parameter int PROG_DEPTH = bfec_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH = bfec_pkg::TAPE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // address[11:0], program_byte[19:12], input_byte[27:20], zero fill
  input  logic [bfec_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[1:0]
  input  logic [bfec_pkg::ACTION_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_valid[0], out_byte[8:1], took_input[9], run_status[11:10], zero fill
  output logic [bfec_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfec_pkg::PLEN_W-1:0]        cfg_data
);

  localparam int PW  = $clog2(PROG_DEPTH + 1);
  localparam int TAW = $clog2(TAPE_DEPTH);

  logic [PW-1:0]  eff_len;
  logic [TAW-1:0] start_cell;
  logic           res_valid, res_ready;
  bfec_pkg::res_t res;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [bfec_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  bfec_cfg #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_len    (eff_len),
    .start_cell (start_cell)
  );

  bfec_core #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_action       (in_tuser),
    .in_address      (in_tdata[11:0]),
    .in_program_byte (in_tdata[19:12]),
    .in_input_byte   (in_tdata[27:20]),
    .eff_len         (eff_len),
    .start_cell      (start_cell),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = bfec_pkg::OUT_TDATA_W'({res.run_status, res.took_input,
                                               res.out_byte, res.out_valid});
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else        out_tvalid_r <= out_tvalid_nxt;
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: design/bfec_cfg.sv
// configuration registers with saturated program length and start cell
module bfec_cfg #(
  parameter int PROG_DEPTH = bfec_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH = bfec_pkg::TAPE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfec_pkg::PLEN_W-1:0]      cfg_data,
  output logic [$clog2(PROG_DEPTH+1)-1:0]  eff_len,
  output logic [$clog2(TAPE_DEPTH)-1:0]    start_cell
);

  localparam int PW  = $clog2(PROG_DEPTH + 1);
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int LW  = (bfec_pkg::PLEN_W > PW) ? bfec_pkg::PLEN_W : PW;
  localparam int SW  = (bfec_pkg::TSTART_W > TAW) ? bfec_pkg::TSTART_W : TAW;

  logic [bfec_pkg::PLEN_W-1:0]   plen_r;
  logic [bfec_pkg::TSTART_W-1:0] tstart_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= bfec_pkg::PROG_LEN_RST;
      tstart_r <= bfec_pkg::TSTART_W'(bfec_pkg::TAPE_START_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        bfec_pkg::CFG_PROGRAM_LENGTH: plen_r   <= cfg_data;
        bfec_pkg::CFG_TAPE_START:     tstart_r <= cfg_data[bfec_pkg::TSTART_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (LW'(plen_r) > LW'(PROG_DEPTH)) eff_len = PW'(PROG_DEPTH);
    else                               eff_len = PW'(plen_r);
  end

  always_comb begin
    if (SW'(tstart_r) >= SW'(TAPE_DEPTH - 1)) start_cell = TAW'(TAPE_DEPTH - 1);
    else                                      start_cell = TAW'(tstart_r);
  end

endmodule

FILE: design/bfec_core.sv
// sequencer around the program store and tape memories
module bfec_core #(
  parameter int PROG_DEPTH = bfec_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH = bfec_pkg::TAPE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bfec_pkg::ACTION_W-1:0]    in_action,
  input  logic [bfec_pkg::ADDR_W-1:0]      in_address,
  input  logic [bfec_pkg::BYTE_W-1:0]      in_program_byte,
  input  logic [bfec_pkg::BYTE_W-1:0]      in_input_byte,
  input  logic [$clog2(PROG_DEPTH+1)-1:0]  eff_len,
  input  logic [$clog2(TAPE_DEPTH)-1:0]    start_cell,
  output logic                             res_valid,
  input  logic                             res_ready,
  output bfec_pkg::res_t                   res
);

  localparam int PW  = $clog2(PROG_DEPTH + 1);
  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int BW  = bfec_pkg::BYTE_W;
  localparam int RST_START = (bfec_pkg::TAPE_START_RST >= TAPE_DEPTH) ?
                             TAPE_DEPTH - 1 : bfec_pkg::TAPE_START_RST;
  localparam logic [TAW-1:0] TAPE_LAST = TAW'(TAPE_DEPTH - 1);

  bfec_pkg::state_t state_r, state_nxt;

  logic [BW-1:0] prog_mem [PROG_DEPTH];
  logic [BW-1:0] tape_mem [TAPE_DEPTH];
  logic [BW-1:0] prog_rdata_r, tape_rdata_r;

  logic           prog_we;
  logic [PAW-1:0] prog_addr;
  logic           tape_we;
  logic [TAW-1:0] tape_addr;
  logic [BW-1:0]  tape_wdata;

  logic [TAW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic                         clr_reply_r, clr_reply_nxt;
  logic [PW-1:0]                ip_r, ip_nxt;
  logic [TAW-1:0]               dp_r, dp_nxt;
  logic [bfec_pkg::STAT_W-1:0]  stop_r, stop_nxt;
  logic [PW-1:0]                scan_r, scan_nxt;
  logic [PW-1:0]                depth_r, depth_nxt;
  logic                         fwd_r, fwd_nxt;
  logic [BW-1:0]                ibyte_r, ibyte_nxt;
  logic                         ov_r, ov_nxt;
  logic [BW-1:0]                ob_r, ob_nxt;
  logic                         ti_r, ti_nxt;

  logic                       accept;
  logic                       clr_last;
  logic                       step_busy;
  logic                       take_scan;
  logic                       scan_err;
  logic [PW-1:0]              scan_step;
  logic                       scan_found;
  logic [BW-1:0]              scan_open, scan_close;
  logic [PW-1:0]              ip_inc;
  logic [PW-1:0]              scan_inc;
  logic [bfec_pkg::ADDR_W-1:0] ld_addr;

  assign accept   = in_valid && (state_r == bfec_pkg::ST_IDLE);
  assign clr_last = (clr_cnt_r == TAPE_LAST);
  assign step_busy = (stop_r == bfec_pkg::STAT_RUN) && (ip_r < eff_len);
  assign ip_inc   = ip_r + 1'b1;
  assign scan_inc = scan_r + 1'b1;

  assign take_scan = ((prog_rdata_r == bfec_pkg::OP_OPEN)  && (tape_rdata_r == '0)) ||
                     ((prog_rdata_r == bfec_pkg::OP_CLOSE) && (tape_rdata_r != '0));

  assign scan_err   = fwd_r ? (scan_inc >= eff_len) : (scan_r == '0);
  assign scan_step  = fwd_r ? scan_inc : scan_r - 1'b1;
  assign scan_open  = fwd_r ? bfec_pkg::OP_OPEN  : bfec_pkg::OP_CLOSE;
  assign scan_close = fwd_r ? bfec_pkg::OP_CLOSE : bfec_pkg::OP_OPEN;
  assign scan_found = (depth_r == '0) && (prog_rdata_r == scan_close);

  // load address folded into the store depth
  always_comb begin
    ld_addr = in_address;
    for (int k = bfec_pkg::ADDR_RED_STEPS - 1; k >= 0; k--) begin
      if (32'(ld_addr) >= (32'(PROG_DEPTH) << k))
        ld_addr = ld_addr - bfec_pkg::ADDR_W'(32'(PROG_DEPTH) << k);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfec_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = clr_reply_r ? bfec_pkg::ST_RESULT : bfec_pkg::ST_IDLE;
      end
      bfec_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            bfec_pkg::ACT_STEP:
              state_nxt = step_busy ? bfec_pkg::ST_EXEC : bfec_pkg::ST_RESULT;
            bfec_pkg::ACT_RESTART: state_nxt = bfec_pkg::ST_CLEAR;
            default:               state_nxt = bfec_pkg::ST_RESULT;
          endcase
        end
      end
      bfec_pkg::ST_EXEC:
        state_nxt = take_scan ? bfec_pkg::ST_SCAN_RD : bfec_pkg::ST_RESULT;
      bfec_pkg::ST_SCAN_RD:
        state_nxt = scan_err ? bfec_pkg::ST_RESULT : bfec_pkg::ST_SCAN_CHK;
      bfec_pkg::ST_SCAN_CHK:
        state_nxt = scan_found ? bfec_pkg::ST_RESULT : bfec_pkg::ST_SCAN_RD;
      bfec_pkg::ST_RESULT: begin
        if (res_ready) state_nxt = bfec_pkg::ST_IDLE;
      end
      default: state_nxt = bfec_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    prog_we       = 1'b0;
    prog_addr     = ip_r[PAW-1:0];
    tape_we       = 1'b0;
    tape_addr     = dp_r;
    tape_wdata    = '0;
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    ip_nxt        = ip_r;
    dp_nxt        = dp_r;
    stop_nxt      = stop_r;
    scan_nxt      = scan_r;
    depth_nxt     = depth_r;
    fwd_nxt       = fwd_r;
    ibyte_nxt     = ibyte_r;
    ov_nxt        = ov_r;
    ob_nxt        = ob_r;
    ti_nxt        = ti_r;
    in_ready      = (state_r == bfec_pkg::ST_IDLE);
    res_valid     = (state_r == bfec_pkg::ST_RESULT);
    res.out_valid  = ov_r;
    res.out_byte   = ob_r;
    res.took_input = ti_r;
    res.run_status = stop_r;

    case (state_r)
      bfec_pkg::ST_CLEAR: begin
        tape_we     = 1'b1;
        tape_addr   = clr_cnt_r;
        clr_cnt_nxt = clr_last ? '0 : clr_cnt_r + 1'b1;
      end
      bfec_pkg::ST_IDLE: begin
        if (accept) begin
          ov_nxt    = 1'b0;
          ob_nxt    = '0;
          ti_nxt    = 1'b0;
          ibyte_nxt = in_input_byte;
          case (in_action)
            bfec_pkg::ACT_LOAD: begin
              prog_we   = 1'b1;
              prog_addr = PAW'(ld_addr);
            end
            bfec_pkg::ACT_STEP: begin
              if ((stop_r == bfec_pkg::STAT_RUN) && (ip_r >= eff_len))
                stop_nxt = bfec_pkg::STAT_DONE;
            end
            bfec_pkg::ACT_RESTART: begin
              ip_nxt        = '0;
              dp_nxt        = start_cell;
              stop_nxt      = bfec_pkg::STAT_RUN;
              clr_reply_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      bfec_pkg::ST_EXEC: begin
        ip_nxt = ip_inc;
        if (ip_inc >= eff_len) stop_nxt = bfec_pkg::STAT_DONE;
        case (prog_rdata_r)
          bfec_pkg::OP_LEFT: begin
            if (dp_r == '0) begin
              ip_nxt   = ip_r;
              stop_nxt = bfec_pkg::STAT_TAPE_ERR;
            end else begin
              dp_nxt = dp_r - 1'b1;
            end
          end
          bfec_pkg::OP_RIGHT: begin
            if (dp_r == TAPE_LAST) begin
              ip_nxt   = ip_r;
              stop_nxt = bfec_pkg::STAT_TAPE_ERR;
            end else begin
              dp_nxt = dp_r + 1'b1;
            end
          end
          bfec_pkg::OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata_r + 1'b1;
          end
          bfec_pkg::OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata_r - 1'b1;
          end
          bfec_pkg::OP_OUT: begin
            ov_nxt = 1'b1;
            ob_nxt = tape_rdata_r;
          end
          bfec_pkg::OP_IN: begin
            tape_we    = 1'b1;
            tape_wdata = ibyte_r;
            ti_nxt     = 1'b1;
          end
          default: ;
        endcase
        if (take_scan) begin
          ip_nxt    = ip_r;
          stop_nxt  = stop_r;
          scan_nxt  = ip_r;
          depth_nxt = '0;
          fwd_nxt   = (prog_rdata_r == bfec_pkg::OP_OPEN);
        end
      end
      bfec_pkg::ST_SCAN_RD: begin
        if (scan_err) begin
          stop_nxt = bfec_pkg::STAT_BRACKET_ERR;
        end else begin
          scan_nxt  = scan_step;
          prog_addr = scan_step[PAW-1:0];
        end
      end
      bfec_pkg::ST_SCAN_CHK: begin
        if (scan_found) begin
          ip_nxt = scan_inc;
          if (scan_inc >= eff_len) stop_nxt = bfec_pkg::STAT_DONE;
        end else if (prog_rdata_r == scan_open) begin
          depth_nxt = depth_r + 1'b1;
        end else if (prog_rdata_r == scan_close) begin
          depth_nxt = depth_r - 1'b1;
        end
      end
      bfec_pkg::ST_RESULT: begin
        if (res_ready) clr_reply_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (prog_we) prog_mem[prog_addr] <= in_program_byte;
    prog_rdata_r <= prog_mem[prog_addr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_addr] <= tape_wdata;
    tape_rdata_r <= tape_mem[tape_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfec_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      ip_r        <= '0;
      dp_r        <= TAW'(RST_START);
      stop_r      <= bfec_pkg::STAT_RUN;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      ip_r        <= ip_nxt;
      dp_r        <= dp_nxt;
      stop_r      <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    depth_r <= depth_nxt;
    fwd_r   <= fwd_nxt;
    ibyte_r <= ibyte_nxt;
    ov_r    <= ov_nxt;
    ob_r    <= ob_nxt;
    ti_r    <= ti_nxt;
  end

endmodule
